[rtl/cws_pkg.sv]
// ----------------------------------------------------------------------------
// cws_pkg
// Shared types and constants of the 3x3 window convolution stream.
// ----------------------------------------------------------------------------
package cws_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CONV_W  = 13;
  localparam int unsigned WROW_W  = 24;
  localparam int unsigned BIAS_W  = 8;
  localparam int unsigned CFG_DW  = 24;
  localparam int unsigned CFG_IW  = 2;
  localparam int unsigned KDIM    = 3;
  localparam int unsigned KTAPS   = KDIM * KDIM;

  // queue between window front and arithmetic back
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = QPTR_W + 1;

  localparam logic signed [BIAS_W-1:0] BIAS_RESET = 8'sd15;

  typedef enum logic [CFG_IW-1:0] {
    CFG_W_TOP = 2'd0,
    CFG_W_MID = 2'd1,
    CFG_W_BOT = 2'd2,
    CFG_BIAS  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [WROW_W-1:0]        w_top;
    logic [WROW_W-1:0]        w_mid;
    logic [WROW_W-1:0]        w_bot;
    logic signed [BIAS_W-1:0] bias;
  } cws_cfg_t;

  // one complete window, row-major, column 2 newest
  typedef struct packed {
    logic [KTAPS-1:0][PIX_W-1:0] pix;
    logic                        last;
  } cws_entry_t;

endpackage

[rtl/cws_px_if.sv]
// ----------------------------------------------------------------------------
// cws_px_if
// Pixel channel: valid/ready handshake with one unsigned 8-bit pixel.
// ----------------------------------------------------------------------------
interface cws_px_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

[rtl/cws_res_if.sv]
// ----------------------------------------------------------------------------
// cws_res_if
// Result channel: valid/ready handshake with window sum and frame end flag.
// ----------------------------------------------------------------------------
interface cws_res_if;
  logic              valid;
  logic              ready;
  logic signed [12:0] conv_value;
  logic              frame_last;

  modport source (output valid, output conv_value, output frame_last, input ready);
  modport sink   (input valid, input conv_value, input frame_last, output ready);
endinterface

[rtl/cws_front.sv]
// ----------------------------------------------------------------------------
// cws_front
// Line stores, 3x3 window and position counters; pushes complete windows.
// ----------------------------------------------------------------------------
module cws_front
  import cws_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH  = 28,
  parameter int unsigned IMAGE_HEIGHT = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cws_px_if.sink      pix_i,
  output logic        push_valid_o,
  output cws_entry_t  push_data_o,
  input  logic        push_ready_i
);

  localparam int unsigned COL_W = (IMAGE_WIDTH  > 1) ? $clog2(IMAGE_WIDTH)  : 1;
  localparam int unsigned ROW_W = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_HEIGHT - 1);
  localparam logic [COL_W-1:0] COL_FIRST_OUT = COL_W'(KDIM - 1);
  localparam logic [ROW_W-1:0] ROW_FIRST_OUT = ROW_W'(KDIM - 1);

  // upper byte: row two above, lower byte: row directly above
  logic [2*PIX_W-1:0]          lines_mem [IMAGE_WIDTH];
  logic [2*PIX_W-1:0]          lines_rd_q;
  logic [COL_W-1:0]            col_q, col_d;
  logic [ROW_W-1:0]            row_q, row_d;
  logic [KTAPS-1:0][PIX_W-1:0] win_q, win_d;
  logic                        accept;
  logic                        produce;

  assign pix_i.ready = push_ready_i;
  assign accept      = pix_i.valid & push_ready_i;
  assign produce     = (row_q >= ROW_FIRST_OUT) && (col_q >= COL_FIRST_OUT);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_q == COL_LAST) begin
        col_d = '0;
        row_d = (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < KDIM; r++) begin
      win_d[r*KDIM]     = win_q[r*KDIM + 1];
      win_d[r*KDIM + 1] = win_q[r*KDIM + 2];
    end
    win_d[2] = lines_rd_q[2*PIX_W-1:PIX_W];
    win_d[5] = lines_rd_q[PIX_W-1:0];
    win_d[8] = pix_i.pixel;
  end

  // read runs one column ahead so the column data is waiting when the pixel comes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lines_mem[col_q] <= {lines_rd_q[PIX_W-1:0], pix_i.pixel};
    end
    lines_rd_q <= lines_mem[col_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      win_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        win_q <= win_d;
      end
    end
  end

  assign push_valid_o     = accept & produce;
  assign push_data_o.pix  = win_d;
  assign push_data_o.last = (row_q == ROW_LAST) && (col_q == COL_LAST);

endmodule

[rtl/cws_queue.sv]
// ----------------------------------------------------------------------------
// cws_queue
// Short window queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module cws_queue
  import cws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  input  cws_entry_t push_data_i,
  output logic       push_ready_o,
  output logic       pop_valid_o,
  output cws_entry_t pop_data_o,
  input  logic       pop_ready_i
);

  cws_entry_t        entries_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push;
  logic              do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[rtl/cws_back.sv]
// ----------------------------------------------------------------------------
// cws_back
// Two-stage arithmetic: nine truncated products, then bias plus sum.
// ----------------------------------------------------------------------------
module cws_back
  import cws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cws_cfg_t   cfg_i,
  input  logic       pop_valid_i,
  input  cws_entry_t pop_data_i,
  output logic       pop_ready_o,
  cws_res_if.source  res_o
);

  logic [KTAPS-1:0][PIX_W-1:0] prod_q, prod_d;
  logic                        s1_valid_q;
  logic                        s1_last_q;
  logic                        s2_valid_q;
  logic                        s2_last_q;
  logic signed [CONV_W-1:0]    s2_sum_q;
  logic signed [CONV_W-1:0]    sum_d;
  logic                        s1_en;
  logic                        s2_en;
  logic [PIX_W-1:0]            wgt;
  logic [WROW_W-1:0]           wrow;

  assign s2_en       = !s2_valid_q || res_o.ready;
  assign s1_en       = !s1_valid_q || s2_en;
  assign pop_ready_o = s1_en;

  // only the low byte of each product is kept
  always_comb begin
    wgt  = '0;
    wrow = '0;
    for (int r = 0; r < KDIM; r++) begin
      for (int c = 0; c < KDIM; c++) begin
        case (r)
          0:       wrow = cfg_i.w_top;
          1:       wrow = cfg_i.w_mid;
          default: wrow = cfg_i.w_bot;
        endcase
        wgt = wrow[c*PIX_W +: PIX_W];
        prod_d[r*KDIM + c] = PIX_W'(wgt * pop_data_i.pix[r*KDIM + c]);
      end
    end
  end

  always_comb begin
    sum_d = {{(CONV_W-BIAS_W){cfg_i.bias[BIAS_W-1]}}, cfg_i.bias};
    for (int i = 0; i < KTAPS; i++) begin
      sum_d = sum_d + $signed({{(CONV_W-PIX_W){1'b0}}, prod_q[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && pop_valid_i) begin
      prod_q    <= prod_d;
      s1_last_q <= pop_data_i.last;
    end
    if (s2_en && s1_valid_q) begin
      s2_sum_q  <= sum_d;
      s2_last_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= pop_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  assign res_o.valid      = s2_valid_q;
  assign res_o.conv_value = s2_sum_q;
  assign res_o.frame_last = s2_last_q;

endmodule

[rtl/conv3x3_window_stream.sv]
// ----------------------------------------------------------------------------
// conv3x3_window_stream
// Valid 3x3 convolution over a raster pixel stream with two line stores.
// ----------------------------------------------------------------------------
//  port        dir   handshake      payload
//  pix_i       in    valid/ready    pixel[7:0] unsigned
//  res_o       out   valid/ready    conv_value[12:0] signed, frame_last
//  cfg_*_i     in    write enable   cfg_idx_i[1:0], cfg_data_i[23:0]
//
// one pixel per cycle while the window queue has room; after the edge that took its
// pixel, a result passes the queue register and the product and sum stages in turn
// a 4-entry window queue decouples the line-store front from the arithmetic
// reset clears counters, window, queue, pipeline valids and registers; the
// line stores are not cleared and need no clearing pass
// a stalled result holds the back; the front keeps taking pixels until the
// queue fills, then every pixel waits until an entry drains
// ----------------------------------------------------------------------------
module conv3x3_window_stream
  import cws_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH  = 28,
  parameter int unsigned IMAGE_HEIGHT = 28
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  cws_px_if.sink            pix_i,
  cws_res_if.source         res_o
);

  cws_cfg_t   cfg_q;
  logic       push_valid;
  cws_entry_t push_data;
  logic       push_ready;
  logic       pop_valid;
  cws_entry_t pop_data;
  logic       pop_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.w_top <= '0;
      cfg_q.w_mid <= '0;
      cfg_q.w_bot <= '0;
      cfg_q.bias  <= BIAS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_W_TOP: cfg_q.w_top <= cfg_data_i[WROW_W-1:0];
        CFG_W_MID: cfg_q.w_mid <= cfg_data_i[WROW_W-1:0];
        CFG_W_BOT: cfg_q.w_bot <= cfg_data_i[WROW_W-1:0];
        CFG_BIAS:  cfg_q.bias  <= cfg_data_i[BIAS_W-1:0];
        default:   cfg_q       <= cfg_q;
      endcase
    end
  end

  cws_front #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  cws_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  cws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .res_o       (res_o)
  );

  // a full queue must hold off the pixel side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_ready |-> !pix_i.ready)
    else $error("pixel side ready while window queue full");

  // a full queue that is not drained stays full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_ready && !(pop_valid && pop_ready)) |=> !push_ready)
    else $error("window queue lost an entry without a pop");

  // a window popped while the result side is ready reaches the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready && res_o.ready) |=> ##1 res_o.valid)
    else $error("popped window did not reach the result register");

endmodule

[dv/conv_window_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv_window_checker
// Watches the pixel, result and register ports of the window convolution,
// slides its own copy of the line stores and 3x3 window on every pixel beat,
// and compares every result beat with the oldest predicted window sum.
// ----------------------------------------------------------------------------
module conv_window_checker
  import cws_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH  = 28,
  parameter int unsigned IMAGE_HEIGHT = 28
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  cws_px_if                 pix_i,
  cws_res_if                res_i,
  output int unsigned       error_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       frames_o
);

  typedef struct packed {
    logic signed [CONV_W-1:0] conv_value;
    logic                     frame_last;
  } sum_beat_t;

  logic [KDIM-1:0][WROW_W-1:0] weight_rows;
  logic signed [BIAS_W-1:0]    bias;

  logic [PIX_W-1:0] row_older [IMAGE_WIDTH];
  logic [PIX_W-1:0] row_newer [IMAGE_WIDTH];
  logic [PIX_W-1:0] window [KTAPS];
  int unsigned      col;
  int unsigned      row;

  sum_beat_t expected_sums [$];

  // bias plus nine products, each cut to its low byte
  function automatic logic signed [CONV_W-1:0] kernel_sum();
    int          acc;
    logic [15:0] prod;
    acc = int'(bias);
    for (int r = 0; r < KDIM; r++) begin
      for (int c = 0; c < KDIM; c++) begin
        prod = weight_rows[r][8*c +: 8] * window[r*KDIM + c];
        acc += int'(prod[7:0]);
      end
    end
    return acc[CONV_W-1:0];
  endfunction

  task automatic slide_window(input logic [PIX_W-1:0] px, output logic hit,
                              output sum_beat_t sum);
    int unsigned      c;
    logic [PIX_W-1:0] up2;
    logic [PIX_W-1:0] up1;
    c = (col >= IMAGE_WIDTH) ? 0 : col;
    up2 = row_older[c];
    up1 = row_newer[c];
    row_older[c] = up1;
    row_newer[c] = px;
    for (int r = 0; r < KDIM; r++) begin
      window[r*KDIM]     = window[r*KDIM + 1];
      window[r*KDIM + 1] = window[r*KDIM + 2];
    end
    window[2] = up2;
    window[5] = up1;
    window[8] = px;
    hit = (row >= 2) && (c >= 2);
    sum.conv_value = kernel_sum();
    sum.frame_last = (row == IMAGE_HEIGHT - 1) && (c == IMAGE_WIDTH - 1);
    c++;
    if (c >= IMAGE_WIDTH) begin
      c = 0;
      row = (row + 1 >= IMAGE_HEIGHT) ? 0 : row + 1;
    end
    col = c;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic      hit;
    sum_beat_t want;
    sum_beat_t got;
    if (!rst_ni) begin
      weight_rows = '0;
      bias = BIAS_RESET;
      for (int i = 0; i < IMAGE_WIDTH; i++) begin
        row_older[i] = '0;
        row_newer[i] = '0;
      end
      for (int i = 0; i < KTAPS; i++) begin
        window[i] = '0;
      end
      col = 0;
      row = 0;
      expected_sums.delete();
      error_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      frames_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_W_TOP: weight_rows[0] = cfg_data_i;
          CFG_W_MID: weight_rows[1] = cfg_data_i;
          CFG_W_BOT: weight_rows[2] = cfg_data_i;
          CFG_BIAS:  bias = cfg_data_i[BIAS_W-1:0];
          default: ;
        endcase
      end
      if (pix_i.valid && pix_i.ready) begin
        slide_window(pix_i.pixel, hit, want);
        if (hit) begin
          expected_sums.push_back(want);
        end
      end
      if (res_i.valid && res_i.ready) begin
        got.conv_value = res_i.conv_value;
        got.frame_last = res_i.frame_last;
        if (expected_sums.size() == 0) begin
          $error("unexpected result beat: conv_value %0d frame_last %0b",
                 got.conv_value, got.frame_last);
          error_count_o++;
        end else begin
          want = expected_sums.pop_front();
          checked_o++;
          if (got.conv_value !== want.conv_value) begin
            $error("conv_value mismatch: expected %0d, actual %0d",
                   want.conv_value, got.conv_value);
            error_count_o++;
          end
          if (got.frame_last !== want.frame_last) begin
            $error("frame_last mismatch: expected %0b, actual %0b",
                   want.frame_last, got.frame_last);
            error_count_o++;
          end
          if (want.frame_last) begin
            frames_o++;
          end
        end
      end
      pending_o = expected_sums.size();
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams pixels through the 3x3 window convolution in phases, each phase
// under its own kernel and bias, with random gaps on both channels in some phases; the
// checker beside the block predicts and compares every window sum.
// ----------------------------------------------------------------------------
module tb_top;
  import cws_pkg::*;

  localparam int unsigned IMG_W           = 28;
  localparam int unsigned IMG_H           = 28;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned PHASE_PIXELS    = 120;
  localparam int unsigned DIRECTED_PIXELS = 25;
  localparam int unsigned FLAT_PHASE      = 4;
  localparam int unsigned IDLE_LIMIT      = 2000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_data;

  cws_px_if  pix_if ();
  cws_res_if res_if ();

  int unsigned error_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned frames;
  int unsigned pixels_sent;
  int unsigned settings_used;
  int unsigned idle_cycles;
  logic        src_gapless;
  logic        sink_gapless;

  conv3x3_window_stream #(
    .IMAGE_WIDTH (IMG_W),
    .IMAGE_HEIGHT(IMG_H)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .pix_i     (pix_if),
    .res_o     (res_if)
  );

  conv_window_checker #(
    .IMAGE_WIDTH (IMG_W),
    .IMAGE_HEIGHT(IMG_H)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pix_i        (pix_if),
    .res_i        (res_if),
    .error_count_o(error_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .frames_o     (frames)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // the run ends if neither channel moves a beat for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel(int unsigned phase, int unsigned k);
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (phase == 0 && k < DIRECTED_PIXELS) begin
      case (k % 6)
        0: return 8'h00;
        1: return 8'hFF;
        2: return 8'h01;
        3: return 8'h80;
        4: return 8'h55;
        default: return 8'hAA;
      endcase
    end
    if (phase == FLAT_PHASE) begin
      return 8'hFF;
    end
    if (roll == 0) begin
      return 8'h00;
    end
    if (roll < 3) begin
      return 8'hFF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] value);
    int unsigned gap;
    gap = src_gapless ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= value;
    do @(posedge clk_i); while (!pix_if.ready);
    pixels_sent++;
  endtask

  // drop valid, wait for every window sum, then let the pipeline empty
  task automatic settle(input int unsigned tail);
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (tail) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
  endtask

  task automatic load_kernel(input logic [WROW_W-1:0] w_top, input logic [WROW_W-1:0] w_mid,
                             input logic [WROW_W-1:0] w_bot, input logic [BIAS_W-1:0] b);
    write_reg(CFG_W_TOP, w_top);
    write_reg(CFG_W_MID, w_mid);
    write_reg(CFG_W_BOT, w_bot);
    write_reg(CFG_BIAS, CFG_DW'(b));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // result side: random stall before each beat while sink_gapless is clear
  initial begin : result_sink
    int unsigned gap;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = sink_gapless ? 0 : $urandom_range(0, 15);
      @(negedge clk_i);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  initial begin : stimulus
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_W_TOP;
    cfg_data     = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    src_gapless  = 1'b1;
    sink_gapless = 1'b1;
    pixels_sent  = 0;
    settings_used = 1;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // first phase runs on the reset kernel: zero weights, bias of fifteen
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        settle(4);
        case (phase)
          1: load_kernel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'h7F);
          2: load_kernel(24'h000000, 24'h000000, 24'h000000, 8'h80);
          FLAT_PHASE: load_kernel(24'h010101, 24'h010101, 24'h010101, 8'h7F);
          default: load_kernel(24'($urandom), 24'($urandom), 24'($urandom),
                               8'($urandom));
        endcase
      end
      src_gapless  = (phase % 2 == 0);
      sink_gapless = (phase % 4 < 2);
      for (int unsigned k = 0; k < PHASE_PIXELS; k++) begin
        push_pixel(pick_pixel(phase, k));
      end
    end
    settle(8);

    $display("streamed %0d pixels under %0d kernel settings", pixels_sent, settings_used);
    $display("checked %0d window sums, %0d frame end(s) seen", checked, frames);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/cws_pkg.sv
rtl/cws_px_if.sv
rtl/cws_res_if.sv
rtl/cws_front.sv
rtl/cws_queue.sv
rtl/cws_back.sv
rtl/conv3x3_window_stream.sv
dv/conv_window_checker.sv
dv/tb_top.sv
